### rtl/core/pcc_pkg.sv
// Shared types and constants for the pixel crossfade compositor core.
`default_nettype none
package pcc_pkg;

  // Fixed point constants
  localparam logic [8:0]  Q8One      = 9'd256;
  localparam logic [15:0] FullScale  = 16'd65280;
  localparam logic [15:0] MixAlphaMin = 16'd7;
  localparam logic [15:0] SkipAlphaMax = 16'd6;
  // ceil(2^40 / 65025); with the low byte dropped, exact for 255 * 65280 on 24 bits
  localparam logic [24:0] OverRecip  = 25'd16909061;
  localparam int unsigned OverShift  = 40;
  localparam logic [7:0]  ChanMax    = 8'd255;

  // Pipeline depth, input register to output register
  localparam int unsigned PipeDepth = 11;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CfgMixWeight = 3'd0,
    CfgXfadeEn   = 3'd1,
    CfgOpacity   = 3'd2,
    CfgTintEn    = 3'd3,
    CfgTintRed   = 3'd4,
    CfgTintGreen = 3'd5,
    CfgTintBlue  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] from_red;
    logic [7:0] from_green;
    logic [7:0] from_blue;
    logic [7:0] from_alpha;
    logic [7:0] to_red;
    logic [7:0] to_green;
    logic [7:0] to_blue;
    logic [7:0] to_alpha;
    logic [7:0] dest_red;
    logic [7:0] dest_green;
    logic [7:0] dest_blue;
    logic [7:0] dest_alpha;
  } pix_req_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       written;
  } pix_rsp_t;

endpackage
`default_nettype wire

### rtl/core/pixel_crossfade_compositor_core.sv
// Throughput: one pixel per cycle; the whole pipe holds while a finished result
// waits, and an empty output register lets every stage advance.
// The crossfade divide is a 4-stage restoring divider, two quotient bits per stage,
// and is the longest part of the pipe; the over-blend divide is a one-stage reciprocal multiply.
// Reset clears valid bits and loads register defaults; no clearing pass.
`default_nettype none
module pixel_crossfade_compositor_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [2:0]        cfg_idx_i,
  input  wire logic [8:0]        cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire pcc_pkg::pix_req_t in_req_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output pcc_pkg::pix_rsp_t      out_rsp_o
);

  typedef logic [3:0][7:0] rgba_t;  // [0..2] color, [3] alpha

  // crossfade divider stage
  typedef struct packed {
    logic [2:0][23:0] rem;
    logic [2:0][7:0]  quo;
    logic [15:0]      a;
    rgba_t            from_px;
    rgba_t            dst_px;
  } xd_t;

  // ---------------- configuration registers ----------------
  logic [8:0] mix_q, op_q;
  logic       xf_q, tint_en_q;
  logic [7:0] tr_q, tg_q, tb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mix_q     <= '0;
      xf_q      <= 1'b0;
      op_q      <= pcc_pkg::Q8One;
      tint_en_q <= 1'b0;
      tr_q      <= pcc_pkg::ChanMax;
      tg_q      <= pcc_pkg::ChanMax;
      tb_q      <= pcc_pkg::ChanMax;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pcc_pkg::CfgMixWeight: mix_q     <= cfg_data_i;
        pcc_pkg::CfgXfadeEn:   xf_q      <= cfg_data_i[0];
        pcc_pkg::CfgOpacity:   op_q      <= cfg_data_i;
        pcc_pkg::CfgTintEn:    tint_en_q <= cfg_data_i[0];
        pcc_pkg::CfgTintRed:   tr_q      <= cfg_data_i[7:0];
        pcc_pkg::CfgTintGreen: tg_q      <= cfg_data_i[7:0];
        pcc_pkg::CfgTintBlue:  tb_q      <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // saturated weights and tint factors
  logic [8:0]      w, wf, op;
  logic [2:0][7:0] tint;
  always_comb begin
    w       = (mix_q > pcc_pkg::Q8One) ? pcc_pkg::Q8One : mix_q;
    wf      = pcc_pkg::Q8One - w;
    op      = (op_q > pcc_pkg::Q8One) ? pcc_pkg::Q8One : op_q;
    tint[0] = tint_en_q ? tr_q : pcc_pkg::ChanMax;
    tint[1] = tint_en_q ? tg_q : pcc_pkg::ChanMax;
    tint[2] = tint_en_q ? tb_q : pcc_pkg::ChanMax;
  end

  // ---------------- handshake and valid bits ----------------
  logic [pcc_pkg::PipeDepth-1:0] vld_q;
  logic                          en;

  assign en          = !vld_q[pcc_pkg::PipeDepth-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[pcc_pkg::PipeDepth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[pcc_pkg::PipeDepth-2:0], in_valid_i};
    end
  end

  // ---------------- stage 1: color times alpha, mixed alpha ----------------
  rgba_t            in_from, in_to, in_dst;
  logic [2:0][15:0] s1_ffa_d, s1_tta_d, s1_ffa_q, s1_tta_q;
  logic [15:0]      s1_a_d, s1_a_q;
  rgba_t            s1_from_q, s1_dst_q;

  always_comb begin
    in_from = {in_req_i.from_alpha, in_req_i.from_blue, in_req_i.from_green,
               in_req_i.from_red};
    in_to   = {in_req_i.to_alpha, in_req_i.to_blue, in_req_i.to_green, in_req_i.to_red};
    in_dst  = {in_req_i.dest_alpha, in_req_i.dest_blue, in_req_i.dest_green,
               in_req_i.dest_red};
    for (int i = 0; i < 3; i++) begin
      s1_ffa_d[i] = 16'(in_from[i]) * 16'(in_from[3]);
      s1_tta_d[i] = 16'(in_to[i]) * 16'(in_to[3]);
    end
    // at most 256 * 255, fits 16 bits
    s1_a_d = 16'(wf) * 16'(in_from[3]) + 16'(w) * 16'(in_to[3]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_ffa_q  <= s1_ffa_d;
      s1_tta_q  <= s1_tta_d;
      s1_a_q    <= s1_a_d;
      s1_from_q <= in_from;
      s1_dst_q  <= in_dst;
    end
  end

  // ---------------- stage 2: weighted color numerators ----------------
  xd_t xd_d [5];
  xd_t xd_q [5];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      xd_d[0].rem[i] = 24'(wf) * 24'(s1_ffa_q[i]) + 24'(w) * 24'(s1_tta_q[i]);
      xd_d[0].quo[i] = '0;
    end
    xd_d[0].a       = s1_a_q;
    xd_d[0].from_px = s1_from_q;
    xd_d[0].dst_px  = s1_dst_q;
  end

  // ---------------- stages 3..6: numerator / mixed alpha ----------------
  for (genvar j = 1; j < 5; j++) begin : g_xdiv
    always_comb begin
      logic [23:0] dv;
      xd_d[j] = xd_q[j-1];
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 2; k++) begin
          dv = {8'd0, xd_q[j-1].a} << (9 - 2 * j - k);
          if (xd_d[j].rem[i] >= dv) begin
            xd_d[j].rem[i] = xd_d[j].rem[i] - dv;
            xd_d[j].quo[i][9 - 2 * j - k] = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 5; j++) begin
        xd_q[j] <= xd_d[j];
      end
    end
  end

  // ---------------- stage 7: source pixel, effective alpha, tint ----------------
  logic [2:0][7:0]  src_c;
  logic [7:0]       src_a;
  logic             a_ok;
  logic [15:0]      s7_p_d, s7_p_q;
  logic             s7_skip_d, s7_skip_q;
  logic [2:0][15:0] s7_st_d, s7_st_q;
  rgba_t            s7_dst_q;

  always_comb begin
    a_ok = xd_q[4].a >= pcc_pkg::MixAlphaMin;
    for (int i = 0; i < 3; i++) begin
      if (xf_q) begin
        src_c[i] = a_ok ? xd_q[4].quo[i] : 8'd0;
      end else begin
        src_c[i] = xd_q[4].from_px[i];
      end
      s7_st_d[i] = 16'(src_c[i]) * 16'(tint[i]);
    end
    if (xf_q) begin
      src_a = a_ok ? xd_q[4].a[15:8] : 8'd0;
    end else begin
      src_a = xd_q[4].from_px[3];
    end
    // at most 255 * 256, fits 16 bits
    s7_p_d    = 16'(src_a) * 16'(op);
    s7_skip_d = (op == '0) || (s7_p_d <= pcc_pkg::SkipAlphaMax);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_p_q    <= s7_p_d;
      s7_skip_q <= s7_skip_d;
      s7_st_q   <= s7_st_d;
      s7_dst_q  <= xd_q[4].dst_px;
    end
  end

  // ---------------- stage 8: source and destination products ----------------
  logic [2:0][31:0] s8_x_d, s8_y_d, s8_x_q, s8_y_q;
  logic [2:0][15:0] d255;
  logic [15:0]      p_inv;
  logic             s8_skip_q;
  rgba_t            s8_dst_q;

  always_comb begin
    p_inv = pcc_pkg::FullScale - s7_p_q;
    for (int i = 0; i < 3; i++) begin
      d255[i]   = {s7_dst_q[i], 8'd0} - 16'(s7_dst_q[i]);
      s8_x_d[i] = 32'(s7_st_q[i]) * 32'(s7_p_q);
      s8_y_d[i] = 32'(d255[i]) * 32'(p_inv);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s8_x_q    <= s8_x_d;
      s8_y_q    <= s8_y_d;
      s8_skip_q <= s7_skip_q;
      s8_dst_q  <= s7_dst_q;
    end
  end

  // ---------------- stage 9: blend numerator ----------------
  logic [2:0][31:0] s9_n_d, s9_n_q;
  logic             s9_skip_q;
  rgba_t            s9_dst_q;

  always_comb begin
    // sum never exceeds 255 * 255 * 65280, fits 32 bits
    for (int i = 0; i < 3; i++) begin
      s9_n_d[i] = s8_x_q[i] + s8_y_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s9_n_q    <= s9_n_d;
      s9_skip_q <= s8_skip_q;
      s9_dst_q  <= s8_dst_q;
    end
  end

  // ---------------- stage 10: divide by 255 * 65280 ----------------
  // drop the low byte (divide by 256), then multiply by the scaled reciprocal of 65025
  logic [2:0][47:0] s10_prod_d, s10_prod_q;
  logic             s10_skip_q;
  rgba_t            s10_dst_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s10_prod_d[i] = 48'(s9_n_q[i][31:8]) * 48'(pcc_pkg::OverRecip);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s10_prod_q <= s10_prod_d;
      s10_skip_q <= s9_skip_q;
      s10_dst_q  <= s9_dst_q;
    end
  end

  // ---------------- stage 11: output register ----------------
  pcc_pkg::pix_rsp_t out_d, out_q;

  always_comb begin
    if (s10_skip_q) begin
      out_d.out_red   = s10_dst_q[0];
      out_d.out_green = s10_dst_q[1];
      out_d.out_blue  = s10_dst_q[2];
      out_d.out_alpha = s10_dst_q[3];
      out_d.written   = 1'b0;
    end else begin
      out_d.out_red   = s10_prod_q[0][47:40];
      out_d.out_green = s10_prod_q[1][47:40];
      out_d.out_blue  = s10_prod_q[2][47:40];
      out_d.out_alpha = pcc_pkg::ChanMax;
      out_d.written   = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_rsp_o = out_q;

`ifndef SYNTH
  // a written pixel is always opaque
  a_written_opaque: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.written |-> out_rsp_o.out_alpha == pcc_pkg::ChanMax)
    else $error("written pixel not opaque");

  // an accepted request occupies the first stage next cycle
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0])
    else $error("accepted request lost at pipe entry");

  // a held pipe keeps every valid bit
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("valid bits moved during stall");

  // a full output register with no taker blocks new requests
  a_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("request taken while output stalled");
`endif

endmodule
`default_nettype wire
